@@ hdl/tagged_free_list_node_store_unit_macros.svh @@
// assertion macros for the tagged free-list node store
`ifndef TAGGED_FREE_LIST_NODE_STORE_UNIT_MACROS_SVH
`define TAGGED_FREE_LIST_NODE_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define TFL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfl check failed: same-cycle implication");
`define TFL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfl check failed: next-cycle implication");
`else
`define TFL_ASSERT_IMP(lbl, ante, cons)
`define TFL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hdl/tfl_pkg.sv @@
// shared types and constants for the tagged free-list node store
package tfl_pkg;

  localparam int MemNodes  = 64;
  localparam int TagChars  = 8;
  localparam int AddrBits  = $clog2(MemNodes);
  localparam int LinkBits  = AddrBits + 1;
  localparam int CountBits = $clog2(MemNodes + 1);
  localparam int TagBits   = 64;
  localparam int ValueBits = 32;

  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [LinkBits-1:0]  link_t;
  typedef logic [CountBits-1:0] count_t;

  localparam link_t NullLink = link_t'(MemNodes);
  localparam logic [TagBits-1:0] TagMask = {TagBits{1'b1}} >> (TagBits - 8 * TagChars);

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0,
    ACT_FREE  = 3'd1,
    ACT_PUT   = 3'd2,
    ACT_GET   = 3'd3,
    ACT_QUERY = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_TAG  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_WR,
    S_FREE_WALK,
    S_MATCH_WALK,
    S_QUERY_WALK,
    S_COUNT_START,
    S_COUNT_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [TagBits-1:0]          tag;
    logic signed [ValueBits-1:0] value;
    link_t                       link;
  } node_t;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    node_t wr_node;
  } mem_req_t;

  // status sits in the lowest bits
  typedef struct packed {
    count_t                      used_count;
    count_t                      free_count;
    logic                        node_is_free;
    logic signed [ValueBits-1:0] read_value;
    addr_t                       node_address;
    status_t                     status;
  } result_t;

  function automatic logic link_valid(link_t l);
    return l < NullLink;
  endfunction

  // after reset node i links to i+1, the last one to null
  function automatic link_t reset_link(addr_t a);
    return link_t'(a) + link_t'(1);
  endfunction

endpackage

@@ hdl/tfl_node_mem.sv @@
// node memory with per-entry valid bits and write-to-read forwarding
module tfl_node_mem (
  input  logic             clk,
  input  logic             rst,
  input  tfl_pkg::mem_req_t req,
  output tfl_pkg::node_t    rd_node
);
  import tfl_pkg::*;

  node_t               mem [MemNodes];
  logic [MemNodes-1:0] vld;
  node_t               rd_raw;
  logic                rd_vld;
  addr_t               rd_addr_q;
  logic                fwd;
  node_t               fwd_node;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_node;
    end
    if (req.rd_en) begin
      rd_raw    <= mem[req.rd_addr];
      rd_addr_q <= req.rd_addr;
      fwd_node  <= req.wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      fwd    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
        // same entry written in the read cycle: take the new word
        fwd    <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd) begin
      rd_node = fwd_node;
    end else if (rd_vld) begin
      rd_node = rd_raw;
    end else begin
      rd_node.tag   = '0;
      rd_node.value = '0;
      rd_node.link  = reset_link(rd_addr_q);
    end
  end

endmodule

@@ hdl/tfl_seq.sv @@
// sequencer that walks node chains and updates the free list
`include "tagged_free_list_node_store_unit_macros.svh"

module tfl_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_action,
  input  tfl_pkg::addr_t                    in_address,
  input  logic [tfl_pkg::TagBits-1:0]       in_tag,
  input  logic signed [tfl_pkg::ValueBits-1:0] in_value,
  input  logic                              in_last,
  output logic                              res_valid,
  input  logic                              res_ready,
  output tfl_pkg::result_t                  result,
  output tfl_pkg::mem_req_t                 mem_req,
  input  tfl_pkg::node_t                    rd_node
);
  import tfl_pkg::*;

  state_t                      state;
  state_t                      state_next;
  action_t                     act;
  addr_t                       addr;
  logic [TagBits-1:0]          tag;
  logic signed [ValueBits-1:0] value;
  logic                        last;
  addr_t                       x;
  count_t                      steps;
  logic                        found;
  link_t                       free_head;
  count_t                      free_nodes;
  status_t                     status;
  addr_t                       node_addr;
  logic signed [ValueBits-1:0] rd_val;
  logic                        is_free;

  link_t   nx;
  logic    nx_ok;
  logic    tag_hit;
  count_t  steps_inc;
  logic    chain_more;
  logic    match_more;
  logic    head_ok;
  action_t in_act;

  assign nx         = rd_node.link;
  assign nx_ok      = link_valid(nx);
  assign tag_hit    = ((rd_node.tag & TagMask) == tag);
  assign steps_inc  = steps + count_t'(1);
  assign chain_more = nx_ok && (steps < count_t'(MemNodes));
  assign match_more = nx_ok && (steps_inc < count_t'(MemNodes));
  assign head_ok    = link_valid(free_head);
  assign in_act     = action_t'(in_action);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_act)
            ACT_ALLOC: state_next = head_ok ? S_ALLOC_WR : S_FINISH;
            ACT_FREE:  state_next = S_FREE_WALK;
            ACT_PUT, ACT_GET: state_next = S_MATCH_WALK;
            ACT_QUERY: begin
              state_next = (head_ok && (free_head != link_t'(in_address))) ?
                           S_QUERY_WALK : S_FINISH;
            end
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_ALLOC_WR:    state_next = S_COUNT_START;
      S_FREE_WALK:   state_next = chain_more ? S_FREE_WALK : S_COUNT_START;
      S_MATCH_WALK: begin
        if ((act == ACT_GET) && tag_hit) begin
          state_next = S_FINISH;
        end else begin
          state_next = match_more ? S_MATCH_WALK : S_FINISH;
        end
      end
      S_QUERY_WALK: begin
        if (!match_more || (nx == link_t'(addr))) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_QUERY_WALK;
        end
      end
      S_COUNT_START: state_next = head_ok ? S_COUNT_WALK : S_FINISH;
      S_COUNT_WALK:  state_next = chain_more ? S_COUNT_WALK : S_FINISH;
      S_FINISH:      state_next = res_ready ? S_IDLE : S_FINISH;
      default:       state_next = S_IDLE;
    endcase
  end

  // handshakes and memory requests
  always_comb begin
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = nx[AddrBits-1:0];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = x;
    mem_req.wr_node = rd_node;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        mem_req.rd_en = in_valid;
        if ((in_act == ACT_ALLOC) || (in_act == ACT_QUERY)) begin
          mem_req.rd_addr = free_head[AddrBits-1:0];
        end else begin
          mem_req.rd_addr = in_address;
        end
      end
      S_ALLOC_WR: begin
        mem_req.wr_en        = 1'b1;
        mem_req.wr_node.tag  = tag;
        mem_req.wr_node.link = last ? NullLink : rd_node.link;
      end
      S_FREE_WALK: begin
        mem_req.rd_en = chain_more;
        if (!chain_more) begin
          // tail reached: splice the chain in front of the free list
          mem_req.wr_en        = 1'b1;
          mem_req.wr_node.link = free_head;
        end
      end
      S_MATCH_WALK: begin
        mem_req.rd_en = match_more && !((act == ACT_GET) && tag_hit);
        if ((act == ACT_PUT) && tag_hit) begin
          mem_req.wr_en         = 1'b1;
          mem_req.wr_node.value = value;
        end
      end
      S_QUERY_WALK:  mem_req.rd_en = match_more && (nx != link_t'(addr));
      S_COUNT_START: begin
        mem_req.rd_en   = head_ok;
        mem_req.rd_addr = free_head[AddrBits-1:0];
      end
      S_COUNT_WALK:  mem_req.rd_en = chain_more;
      S_FINISH:      res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= link_t'(0);
      free_nodes <= count_t'(MemNodes);
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act       <= in_act;
            addr      <= in_address;
            tag       <= in_tag & TagMask;
            value     <= in_value;
            last      <= in_last;
            found     <= 1'b0;
            status    <= ST_OK;
            node_addr <= '0;
            rd_val    <= '0;
            is_free   <= 1'b0;
            steps     <= (in_act == ACT_FREE) ? count_t'(1) : count_t'(0);
            if ((in_act == ACT_ALLOC) || (in_act == ACT_QUERY)) begin
              x <= free_head[AddrBits-1:0];
            end else begin
              x <= in_address;
            end
            if (in_act == ACT_ALLOC) begin
              if (head_ok) begin
                node_addr <= free_head[AddrBits-1:0];
              end else begin
                status <= ST_NO_SPACE;
              end
            end
            if ((in_act == ACT_QUERY) && head_ok && (free_head == link_t'(in_address))) begin
              is_free <= 1'b1;
            end
          end
        end
        S_ALLOC_WR: free_head <= rd_node.link;
        S_FREE_WALK: begin
          if (chain_more) begin
            x     <= nx[AddrBits-1:0];
            steps <= steps_inc;
          end else begin
            free_head <= link_t'(addr);
          end
        end
        S_MATCH_WALK: begin
          if (tag_hit) begin
            found <= 1'b1;
            if (act == ACT_GET) begin
              rd_val <= rd_node.value;
            end
          end
          if (match_more) begin
            x     <= nx[AddrBits-1:0];
            steps <= steps_inc;
          end
          if (!(found || tag_hit) && !match_more) begin
            status <= ST_NO_TAG;
          end
        end
        S_QUERY_WALK: begin
          if (match_more) begin
            x     <= nx[AddrBits-1:0];
            steps <= steps_inc;
            if (nx == link_t'(addr)) begin
              is_free <= 1'b1;
            end
          end
        end
        S_COUNT_START: begin
          x     <= free_head[AddrBits-1:0];
          steps <= count_t'(1);
          if (!head_ok) begin
            free_nodes <= '0;
          end
        end
        S_COUNT_WALK: begin
          if (chain_more) begin
            x     <= nx[AddrBits-1:0];
            steps <= steps_inc;
          end else begin
            free_nodes <= steps;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.status       = status;
  assign result.node_address = node_addr;
  assign result.read_value   = rd_val;
  assign result.node_is_free = is_free;
  assign result.free_count   = free_nodes;
  assign result.used_count   = count_t'(MemNodes) - free_nodes;

  `TFL_ASSERT_IMP(a_walk_bound, (state == S_FREE_WALK || state == S_COUNT_WALK), (steps != count_t'(0) && steps <= count_t'(MemNodes)))
  `TFL_ASSERT_IMP(a_match_bound, (state == S_MATCH_WALK || state == S_QUERY_WALK), (steps < count_t'(MemNodes)))
  `TFL_ASSERT_NXT(a_alloc_recount, (state == S_ALLOC_WR), (state == S_COUNT_START))
  `TFL_ASSERT_IMP(a_finish_quiet, (state == S_FINISH), (!mem_req.rd_en && !mem_req.wr_en))

endmodule

@@ hdl/tagged_free_list_node_store_unit.sv @@
// top level of the tagged free-list node store
//
// One request beat on s_axis gives one result beat on m_axis. The action code
// travels in s_axis_tuser: alloc, free chain, put value, get value, query.
// A run of allocs ends on the beat with s_axis_tlast set, which closes the
// chain. Nodes live in a 64-entry memory with registered reads.
// A request is taken only while no earlier one is in work; the finished
// result sits in the m_axis output register, so a stalled receiver holds the
// next request back only when that register is still full at the end of work.
// Work per request; every chain walk reads one node per cycle:
//   alloc: write the node, then walk the free list to recount it
//   free: walk the chain to its tail, splice it in, then recount the free list
//   put, get: walk the chain; query: walk the free list; a get hit or a query hit ends early
//   unknown action: straight to the result
// Reset puts every node on the free list in index order, with zero tags and
// values; no clearing pass is needed and the first request can follow
// directly.
module tagged_free_list_node_store_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // address[5:0], tag[69:6], value[101:70]
  input  logic [2:0]   s_axis_tuser,  // action[2:0]
  input  logic         s_axis_tlast,  // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata   // status, node_address, read_value,
                                      // node_is_free, free_count, used_count
);
  import tfl_pkg::*;

  mem_req_t mem_req;
  node_t    rd_node;
  result_t  result;
  result_t  out_q;
  logic     res_valid;
  logic     res_ready;

  tfl_node_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_node (rd_node)
  );

  tfl_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser),
    .in_address (s_axis_tdata[AddrBits-1:0]),
    .in_tag     (s_axis_tdata[AddrBits+TagBits-1:AddrBits]),
    .in_value   (s_axis_tdata[AddrBits+TagBits+ValueBits-1:AddrBits+TagBits]),
    .in_last    (s_axis_tlast),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .result     (result),
    .mem_req    (mem_req),
    .rd_node    (rd_node)
  );

  // output register: free, or emptied by the receiver this cycle
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= result;
    end
  end

  assign m_axis_tdata = {1'b0, out_q};

endmodule

@@ tb/tagged_free_list_node_store_unit_tb.sv @@
// self-checking testbench for the tagged free-list node store, with a local prediction model
module tagged_free_list_node_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfl_pkg::*;

  localparam int WatchLimit  = 3000;
  localparam int HoldCycles  = 400;
  localparam int RandomItems = 1950;
  localparam int BlockItems  = 150;
  localparam int TailCycles  = 150;

  typedef struct {
    logic [2:0]         act;
    addr_t              addr;
    logic [TagBits-1:0] tag;
    logic [31:0]        val;
    logic               last;
    int unsigned        gap;
  } request_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // address[5:0], tag[69:6], value[101:70]
  logic [2:0]   s_axis_tuser = '0;  // action[2:0]
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;       // status, node_address, read_value,
                                    // node_is_free, free_count, used_count

  request_t request_queue[$];
  request_t staged;
  logic     staged_ok = 1'b0;
  result_t  pending_results[$];
  addr_t    chain_heads[$];
  addr_t    run_head;
  logic     run_open = 1'b0;
  logic     idle_on = 1'b1;
  int       rx_wait = 0;
  int       hold_left = 0;
  int       hold_asks = 0;
  int       holds_done = 0;
  int       mismatches = 0;
  int       useful_offers = 0;
  int       quiet_cycles = 0;
  logic [TagBits-1:0] tag_pool[6];

  // model of the node store
  logic [TagBits-1:0] tag_mem[MemNodes];
  logic [31:0]        val_mem[MemNodes];
  link_t              link_mem[MemNodes];
  link_t              free_head;
  count_t             free_len;

  tagged_free_list_node_store_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_store();
    for (int i = 0; i < MemNodes; i++) begin
      tag_mem[i]  = '0;
      val_mem[i]  = '0;
      link_mem[i] = link_t'(i + 1);
    end
    free_head = '0;
    free_len  = count_t'(MemNodes);
  endfunction

  // bounded walk, so a cyclic free list still counts at most MemNodes
  function automatic count_t free_list_length();
    link_t x;
    int    n;
    x = free_head;
    n = 0;
    while (x < NullLink && n < MemNodes) begin
      n++;
      x = link_mem[x[AddrBits-1:0]];
    end
    return count_t'(n);
  endfunction

  function automatic result_t apply_request(logic [2:0] act, addr_t addr,
                                            logic [TagBits-1:0] tag_in, logic [31:0] val,
                                            logic last);
    result_t            r;
    link_t              x;
    int                 steps;
    logic               hit;
    logic               done;
    logic [TagBits-1:0] tag;
    r   = '0;
    tag = tag_in & TagMask;
    case (act)
      ACT_ALLOC: begin
        if (free_head >= NullLink) begin
          r.status = ST_NO_SPACE;
        end else begin
          x = free_head;
          tag_mem[x[AddrBits-1:0]] = tag;
          free_head = link_mem[x[AddrBits-1:0]];
          if (last) link_mem[x[AddrBits-1:0]] = NullLink;
          r.node_address = x[AddrBits-1:0];
          free_len = free_list_length();
        end
      end
      ACT_FREE: begin
        x = link_t'(addr);
        steps = 1;
        while (link_mem[x[AddrBits-1:0]] < NullLink && steps < MemNodes) begin
          x = link_mem[x[AddrBits-1:0]];
          steps++;
        end
        link_mem[x[AddrBits-1:0]] = free_head;
        free_head = link_t'(addr);
        free_len = free_list_length();
      end
      ACT_PUT, ACT_GET: begin
        x = link_t'(addr);
        steps = 0;
        hit = 1'b0;
        done = 1'b0;
        while (!done && x < NullLink && steps < MemNodes) begin
          if (tag_mem[x[AddrBits-1:0]] == tag) begin
            hit = 1'b1;
            if (act == ACT_GET) begin
              r.read_value = val_mem[x[AddrBits-1:0]];
              done = 1'b1;
            end else begin
              val_mem[x[AddrBits-1:0]] = val;
            end
          end
          if (!done) begin
            x = link_mem[x[AddrBits-1:0]];
            steps++;
          end
        end
        if (!hit) r.status = ST_NO_TAG;
      end
      ACT_QUERY: begin
        x = free_head;
        steps = 0;
        done = 1'b0;
        while (!done && x < NullLink && steps < MemNodes) begin
          if (x == link_t'(addr)) begin
            r.node_is_free = 1'b1;
            done = 1'b1;
          end else begin
            x = link_mem[x[AddrBits-1:0]];
            steps++;
          end
        end
      end
      default: ;
    endcase
    r.free_count = free_len;
    r.used_count = count_t'(MemNodes) - free_len;
    return r;
  endfunction

  task automatic compare_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("%s mismatch: expected %0h, got %0h", fname, want, got);
    end
  endtask

  // driver: each item waits its own gap before it is offered
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      staged_ok = 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (!staged_ok && request_queue.size() != 0) begin
        staged = request_queue.pop_front();
        staged_ok = 1'b1;
      end
      if (staged_ok && staged.gap == 0) begin
        s_axis_tdata  <= {2'b00, staged.val, staged.tag, staged.addr};
        s_axis_tuser  <= staged.act;
        s_axis_tlast  <= staged.last;
        s_axis_tvalid <= 1'b1;
        staged_ok = 1'b0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (staged_ok) staged.gap--;
      end
    end
  end

  // monitor: predicts on every request beat, checks every result beat
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      clear_store();
      pending_results.delete();
      chain_heads.delete();
      run_open = 1'b0;
      rx_wait = 0;
      hold_left = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[54:0]);
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat with no request pending: expected none, got %0h",
                     m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 64'(want.status), 64'(got.status));
          compare_field("node_address", 64'(want.node_address), 64'(got.node_address));
          compare_field("read_value", 64'(want.read_value), 64'(got.read_value));
          compare_field("node_is_free", 64'(want.node_is_free), 64'(got.node_is_free));
          compare_field("free_count", 64'(want.free_count), 64'(got.free_count));
          compare_field("used_count", 64'(want.used_count), 64'(got.used_count));
        end
        rx_wait = idle_on ? $urandom_range(0, 6) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left = HoldCycles;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_request(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[69:6],
                             s_axis_tdata[101:70], s_axis_tlast);
        pending_results.push_back(want);
        // remember chain heads so later requests can walk real chains
        if (s_axis_tuser == ACT_ALLOC && want.status == ST_OK) begin
          if (!run_open) begin
            run_head = want.node_address;
            run_open = 1'b1;
          end
          if (s_axis_tlast) begin
            chain_heads.push_back(run_head);
            run_open = 1'b0;
          end
        end else if (s_axis_tuser == ACT_FREE) begin
          for (int i = chain_heads.size() - 1; i >= 0; i--)
            if (chain_heads[i] == s_axis_tdata[5:0]) chain_heads.delete(i);
        end
      end
      m_axis_tready <= (rx_wait == 0 && hold_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(logic [2:0] act, addr_t addr, logic [TagBits-1:0] tag,
                       logic [31:0] val, logic last);
    request_t r;
    while (request_queue.size() != 0) @(negedge clk);
    r.act  = act;
    r.addr = addr;
    r.tag  = tag;
    r.val  = val;
    r.last = last;
    r.gap  = idle_on ? $urandom_range(0, 6) : 0;
    request_queue.push_back(r);
    if (act <= ACT_QUERY) useful_offers++;
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || staged_ok || s_axis_tvalid ||
           pending_results.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [TagBits-1:0] pick_tag();
    if ($urandom_range(0, 5) == 0) return {$urandom, $urandom};
    return tag_pool[$urandom_range(0, 5)];
  endfunction

  function automatic addr_t pick_head(logic clean);
    if (chain_heads.size() != 0 && (clean || $urandom_range(0, 7) != 0))
      return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
    return addr_t'($urandom_range(0, MemNodes - 1));
  endfunction

  // one well-formed sequence, or a noise beat when not in clean mode
  task automatic random_round(logic clean, logic fill);
    int k;
    int len;
    k = $urandom_range(0, 99);
    if (k < (fill ? 45 : 20)) begin
      len = fill ? $urandom_range(1, 24) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        offer(ACT_ALLOC, addr_t'($urandom), pick_tag(), $urandom, i == len - 1);
    end else if (k < 60) begin
      offer(ACT_PUT, pick_head(clean), pick_tag(), $urandom, 1'($urandom));
    end else if (k < 75) begin
      offer(ACT_GET, pick_head(clean), pick_tag(), $urandom, 1'($urandom));
    end else if (k < 82 || (clean && chain_heads.size() == 0)) begin
      offer(ACT_QUERY, addr_t'($urandom), {$urandom, $urandom}, $urandom, 1'($urandom));
    end else if (k < 92 || clean) begin
      offer(ACT_FREE, pick_head(clean), {$urandom, $urandom}, $urandom, 1'($urandom));
    end else begin
      offer(3'($urandom_range(0, 7)), addr_t'($urandom), {$urandom, $urandom}, $urandom,
            1'($urandom));
    end
  endtask

  initial begin : stimulus
    int   base;
    int   blk;
    int   in_blk;
    logic clean;
    logic fill;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // chain of three nodes 0, 1, 2, two of them with extreme tags
    offer(ACT_ALLOC, '0, '0, '0, 1'b0);
    offer(ACT_ALLOC, '1, '1, '1, 1'b0);
    offer(ACT_ALLOC, '0, 64'h0000_0000_0061_6765, '0, 1'b1);
    offer(ACT_PUT, 6'd0, '1, 32'h7fff_ffff, 1'b0);
    offer(ACT_PUT, 6'd0, '0, 32'h8000_0000, 1'b1);
    offer(ACT_GET, 6'd0, '1, '0, 1'b0);
    offer(ACT_GET, 6'd0, '0, '0, 1'b1);
    // tag nowhere in the chain
    offer(ACT_GET, 6'd0, 64'h0000_0000_0000_7a7a, '0, 1'b0);
    offer(ACT_PUT, 6'd0, 64'h0000_0000_0000_7a7a, 32'h0000_1234, 1'b0);
    offer(ACT_QUERY, 6'd0, '0, '0, 1'b0);
    offer(ACT_QUERY, 6'd63, '0, '0, 1'b0);
    offer(ACT_QUERY, 6'd3, '0, '0, 1'b0);
    offer(ACT_ALLOC, '0, 64'h0000_0000_0000_7475, '0, 1'b1);
    offer(ACT_FREE, 6'd0, '0, '0, 1'b0);
    offer(ACT_QUERY, 6'd1, '0, '0, 1'b0);
    // untouched free node still carries the empty tag
    offer(ACT_GET, 6'd63, '0, '0, 1'b0);
    offer(ACT_GET, 6'd3, 64'h0000_0000_0000_7475, '0, 1'b0);
    for (int a = ACT_QUERY + 1; a < 8; a++)
      offer(3'(a), addr_t'($urandom), {$urandom, $urandom}, $urandom, 1'($urandom));
    offer(ACT_FREE, 6'd3, '0, '0, 1'b1);
    wait_drained();

    // first block stays free of double frees so the store can run dry
    base = useful_offers;
    blk = 0;
    while (useful_offers - base < RandomItems) begin
      clean = (blk == 0);
      fill = clean || 1'($urandom_range(0, 1));
      idle_on = (blk == 0) || ($urandom_range(0, 3) != 0);
      if (blk == 1 || blk == 5) hold_asks++;
      in_blk = useful_offers;
      while (useful_offers - in_blk < BlockItems && useful_offers - base < RandomItems)
        random_round(clean, fill);
      wait_drained();
      blk++;
    end

    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tfl_pkg.sv
hdl/tfl_node_mem.sv
hdl/tfl_seq.sv
hdl/tagged_free_list_node_store_unit.sv
tb/tagged_free_list_node_store_unit_tb.sv
